/* src/cmc_pkg.sv */
// ---------------------------------------------------------------------------
// cmc_pkg
// Shared types, constants and helper functions of the colinear mapping chainer.
// ---------------------------------------------------------------------------
package cmc_pkg;

  localparam int DEF_MAX_MAPPINGS  = 64;
  localparam int DEF_POSITION_BITS = 32;

  localparam int FIELD_W   = 32;   // width of position fields on the ports
  localparam int POS_MAX_W = 40;   // largest supported position width
  localparam int SUM_W     = 40;   // width of saturating length sums
  localparam int REL_W     = 16;   // relative gap limit, unsigned Q8.8
  localparam int CFG_IDX_W = 2;

  localparam logic [CFG_IDX_W-1:0] CFG_ABS_GAP     = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_REL_GAP     = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_GENOME_SIZE = 2'd2;

  typedef enum logic [1:0] {
    ST_CHAINED    = 2'd0,
    ST_MISASM     = 2'd1,
    ST_NON_UNIQUE = 2'd2,
    ST_UNMAPPED   = 2'd3
  } status_t;

  typedef struct packed {
    logic [FIELD_W-1:0] initial_start;
    logic [FIELD_W-1:0] initial_end;
    logic [FIELD_W-1:0] mapped_start;
    logic [FIELD_W-1:0] mapped_end;
    logic [FIELD_W-1:0] edge_length;
    logic               last_mapping;
  } in_item_t;

  typedef struct packed {
    status_t            status;
    logic [FIELD_W-1:0] merged_initial_start;
    logic [FIELD_W-1:0] merged_initial_end;
    logic [FIELD_W-1:0] merged_mapped_start;
    logic [FIELD_W-1:0] merged_mapped_end;
    logic [SUM_W-1:0]   loaded_length;
    logic [SUM_W-1:0]   chained_length;
  } out_item_t;

  // Size of a range; a reversed range has size zero.
  function automatic logic [POS_MAX_W-1:0] span_len(input logic [POS_MAX_W-1:0] s,
                                                    input logic [POS_MAX_W-1:0] e);
    return (e >= s) ? (e - s) : '0;
  endfunction

  // Addition that saturates at the all-ones value of a sum.
  function automatic logic [SUM_W-1:0] sat_add(input logic [SUM_W-1:0] a,
                                               input logic [SUM_W-1:0] b);
    logic [SUM_W:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[SUM_W] ? {SUM_W{1'b1}} : s[SUM_W-1:0];
  endfunction

endpackage

/* src/cmc_cell.sv */
// ---------------------------------------------------------------------------
// cmc_cell
// One storage cell of the mapping ring; takes its neighbor's entry on a shift.
// ---------------------------------------------------------------------------
module cmc_cell #(
  parameter int EW = 8
) (
  input  logic          clk,
  input  logic          shift_en,
  input  logic [EW-1:0] d,
  output logic [EW-1:0] q
);

  logic [EW-1:0] entry_r;

  always_ff @(posedge clk) begin
    if (shift_en) begin
      entry_r <= d;
    end
  end

  assign q = entry_r;

endmodule

/* src/cmc_link.sv */
// ---------------------------------------------------------------------------
// cmc_link
// Consistency test between the held row mapping and the ring head, and the
// chain score update of the head entry.
// ---------------------------------------------------------------------------
module cmc_link #(
  parameter int P  = 32,
  parameter int IW = 6
) (
  input  logic [6*P+cmc_pkg::SUM_W+IW:0]   row,
  input  logic [IW-1:0]                    row_idx,
  input  logic [6*P+cmc_pkg::SUM_W+IW:0]   head,
  input  logic                             upd_en,
  input  logic [cmc_pkg::FIELD_W-1:0]      abs_gap,
  input  logic [cmc_pkg::REL_W-1:0]        rel_gap,
  input  logic [cmc_pkg::FIELD_W-1:0]      genome_size,
  output logic [6*P+cmc_pkg::SUM_W+IW:0]   head_upd,
  output logic                             stop
);
  import cmc_pkg::*;

  localparam int O_IS  = 0;
  localparam int O_IE  = P;
  localparam int O_MS  = 2*P;
  localparam int O_ME  = 3*P;
  localparam int O_SZ  = 4*P;
  localparam int O_MSZ = 5*P;
  localparam int O_SC  = 6*P;
  localparam int O_PR  = 6*P + SUM_W;
  localparam int O_PV  = 6*P + SUM_W + IW;
  localparam int AW    = ((P > FIELD_W) ? P : FIELD_W) + 1;
  localparam int RW    = AW + REL_W + 8;

  logic [AW-1:0]    ei, mei, sj, msj, a, g;
  logic [AW-1:0]    g1, g2, mg;
  logic [P-1:0]     mszi, mszj, mm;
  logic [RW-1:0]    lhs, rhs;
  logic             wrap, near_i, near_m, cons;
  logic [SUM_W-1:0] cand, score_j;

  always_comb begin
    ei   = AW'(row[O_IE +: P]);
    mei  = AW'(row[O_ME +: P]);
    sj   = AW'(head[O_IS +: P]);
    msj  = AW'(head[O_MS +: P]);
    a    = AW'(abs_gap);
    g    = AW'(genome_size);
    mszi = row[O_MSZ +: P];
    mszj = head[O_MSZ +: P];

    wrap   = (sj <= a) && ((ei + a) >= g);
    near_i = !(ei > (sj + a)) && !((ei + a) < sj);
    near_m = !(mei > (msj + a)) && !((mei + a) < msj);
    g1     = (ei > sj) ? (ei - sj) : (sj - ei);
    g2     = (mei > msj) ? (mei - msj) : (msj - mei);
    mg     = (g1 > g2) ? g1 : g2;
    mm     = (mszi > mszj) ? mszi : mszj;
    lhs    = RW'({mg, 8'h00});
    rhs    = RW'(rel_gap) * RW'(mm);
    cons   = wrap || (near_i && near_m && (lhs <= rhs));

    score_j = head[O_SC +: SUM_W];
    cand    = sat_add(row[O_SC +: SUM_W], SUM_W'(head[O_SZ +: P]));

    head_upd = head;
    if (upd_en && cons && (score_j < cand)) begin
      head_upd[O_SC +: SUM_W] = cand;
      head_upd[O_PR +: IW]    = row_idx;
      head_upd[O_PV]          = 1'b1;
    end
    stop = upd_en && !cons && (msj > (mei + a));
  end

endmodule

/* src/colinear_mapping_chainer.sv */
// ---------------------------------------------------------------------------
// colinear_mapping_chainer
// Collects the mappings of one edge, classifies the edge and chains the
// consistent mappings into one merged span.
// ---------------------------------------------------------------------------
// Mappings enter one item per cycle while in_stall is low, sorted by mapped
// start, and are kept in a ring of MAX_MAPPINGS cells that rotates by one cell
// per load. Only an item with last_mapping set costs time: the block then
// classifies the edge and, if the edge is neither non-unique nor unmapped, runs
// the chaining. Chaining first waits up to one ring revolution for mapping 0 to
// reach the head, then takes one full revolution per loaded mapping, one more
// revolution to find the best chain end, and up to one revolution per chain
// member to walk the chain back, all through the single compare unit at the
// ring head. While that runs in_stall is high; configuration writes are always
// taken and must only happen while the block is idle. The result waits in an
// output register, so loading of the next edge can start while the previous
// result is still stalled. Mappings beyond MAX_MAPPINGS are dropped, and
// positions are cut to POSITION_BITS bits.
// ---------------------------------------------------------------------------
module colinear_mapping_chainer #(
  parameter int MAX_MAPPINGS  = cmc_pkg::DEF_MAX_MAPPINGS,
  parameter int POSITION_BITS = cmc_pkg::DEF_POSITION_BITS
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  cmc_pkg::in_item_t             in_item,
  output logic                          out_valid,
  input  logic                          out_stall,
  output cmc_pkg::out_item_t            out_item,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [cmc_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [cmc_pkg::FIELD_W-1:0]   cfg_data
);
  import cmc_pkg::*;

  localparam int N     = MAX_MAPPINGS;
  localparam int P     = POSITION_BITS;
  localparam int IW    = $clog2(N);
  localparam int CW    = $clog2(N + 1);
  localparam int O_IS  = 0;
  localparam int O_IE  = P;
  localparam int O_MS  = 2*P;
  localparam int O_ME  = 3*P;
  localparam int O_SZ  = 4*P;
  localparam int O_MSZ = 5*P;
  localparam int O_SC  = 6*P;
  localparam int O_PR  = 6*P + SUM_W;
  localparam int O_PV  = 6*P + SUM_W + IW;
  localparam int EW    = O_PV + 1;

  typedef enum logic [2:0] {
    S_IDLE, S_CLASS, S_DP, S_MAX, S_TRACE, S_FIN, S_OUT
  } state_t;

  state_t              state_r;
  logic [EW-1:0]       ring [N];
  logic [EW-1:0]       head, head_upd, tail, new_entry, row_r;
  logic [FIELD_W-1:0]  abs_gap_r, genome_r, len_r;
  logic [REL_W-1:0]    rel_gap_r;
  logic [CW-1:0]       cnt_r;
  logic [SUM_W-1:0]    total_r, best_r, used_r;
  logic [IW-1:0]       hidx_r, hidx_nxt, i_r, cur_r;
  logic                have_row_r, brk_r, out_valid_r;
  logic [P-1:0]        mis_r, mie_r, mms_r, mme_r;
  out_item_t           res_r, res_nxt, out_item_r;
  logic                in_acc, store_new, shift_en, upd_en, stop;
  logic                in_range, hidx_last;
  logic [P-1:0]        n_is, n_ie, n_ms, n_me, n_sz, n_msz;
  logic [SUM_W-1:0]    head_score, head_sz, diff;
  logic [SUM_W+1:0]    tot2, len3;
  logic [SUM_W+3:0]    diff10;
  logic [POS_MAX_W-1:0] ext_is, ext_ie, ext_ms, ext_me;

  assign in_stall  = (state_r != S_IDLE);
  assign in_acc    = in_valid && !in_stall;
  assign store_new = in_acc && (cnt_r != CW'(N));
  assign cfg_ready = 1'b1;
  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;

  // New ring entry: positions, sizes and the starting score of the mapping.
  always_comb begin
    n_is  = P'(POS_MAX_W'(in_item.initial_start));
    n_ie  = P'(POS_MAX_W'(in_item.initial_end));
    n_ms  = P'(POS_MAX_W'(in_item.mapped_start));
    n_me  = P'(POS_MAX_W'(in_item.mapped_end));
    n_sz  = P'(span_len(POS_MAX_W'(n_is), POS_MAX_W'(n_ie)));
    n_msz = P'(span_len(POS_MAX_W'(n_ms), POS_MAX_W'(n_me)));
    if (n_sz < n_msz) begin
      n_msz = n_sz;
    end
    new_entry               = '0;
    new_entry[O_IS +: P]    = n_is;
    new_entry[O_IE +: P]    = n_ie;
    new_entry[O_MS +: P]    = n_ms;
    new_entry[O_ME +: P]    = n_me;
    new_entry[O_SZ +: P]    = n_sz;
    new_entry[O_MSZ +: P]   = n_msz;
    new_entry[O_SC +: SUM_W] = SUM_W'(n_sz);
  end

  // The ring: cell c holds mapping (hidx_r + c) mod N; cell 0 is the head.
  assign head     = ring[0];
  assign tail     = (state_r == S_IDLE) ? new_entry : head_upd;
  assign shift_en = store_new || (state_r == S_DP) || (state_r == S_MAX) ||
                    (state_r == S_TRACE);

  genvar c;
  generate
    for (c = 0; c < N; c++) begin : g_ring
      if (c == N - 1) begin : g_tail
        cmc_cell #(.EW(EW)) u_cell (
          .clk(clk), .shift_en(shift_en), .d(tail), .q(ring[c])
        );
      end else begin : g_mid
        cmc_cell #(.EW(EW)) u_cell (
          .clk(clk), .shift_en(shift_en), .d(ring[c+1]), .q(ring[c])
        );
      end
    end
  endgenerate

  // Row mapping i is compared against every later mapping as it passes the
  // head; the pruning rule stops updates for the rest of the revolution.
  assign upd_en = (state_r == S_DP) && have_row_r && !brk_r && (hidx_r > i_r) &&
                  in_range;

  cmc_link #(.P(P), .IW(IW)) u_link (
    .row(row_r), .row_idx(i_r), .head(head), .upd_en(upd_en),
    .abs_gap(abs_gap_r), .rel_gap(rel_gap_r), .genome_size(genome_r),
    .head_upd(head_upd), .stop(stop)
  );

  always_comb begin
    hidx_last  = (hidx_r == IW'(N - 1));
    hidx_nxt   = hidx_last ? '0 : hidx_r + 1'b1;
    in_range   = (CW'(hidx_r) < cnt_r);
    head_score = head[O_SC +: SUM_W];
    head_sz    = SUM_W'(head[O_SZ +: P]);
    tot2       = {1'b0, total_r, 1'b0};
    len3       = (SUM_W+2)'(len_r) * (SUM_W+2)'(3);
    diff       = (total_r > used_r) ? (total_r - used_r) : '0;
    diff10     = (SUM_W+4)'(diff) * (SUM_W+4)'(10);
    ext_is     = POS_MAX_W'(mis_r);
    ext_ie     = POS_MAX_W'(mie_r);
    ext_ms     = POS_MAX_W'(mms_r);
    ext_me     = POS_MAX_W'(mme_r);

    // Result of the edge: the classification, or the merged chain at the end.
    res_nxt               = '0;
    res_nxt.loaded_length = total_r;
    if (state_r == S_FIN) begin
      res_nxt.status               = (diff10 >= (SUM_W+4)'(len_r)) ? ST_MISASM
                                                                   : ST_CHAINED;
      res_nxt.merged_initial_start = ext_is[FIELD_W-1:0];
      res_nxt.merged_initial_end   = ext_ie[FIELD_W-1:0];
      res_nxt.merged_mapped_start  = ext_ms[FIELD_W-1:0];
      res_nxt.merged_mapped_end    = ext_me[FIELD_W-1:0];
      res_nxt.chained_length       = used_r;
    end else if ((cnt_r == '0) || (tot2 < (SUM_W+2)'(len_r))) begin
      res_nxt.status = ST_UNMAPPED;
    end else begin
      res_nxt.status = ST_NON_UNIQUE;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      abs_gap_r   <= '0;
      rel_gap_r   <= '0;
      genome_r    <= '0;
      cnt_r       <= '0;
      total_r     <= '0;
      hidx_r      <= '0;
      have_row_r  <= 1'b0;
      brk_r       <= 1'b0;
      out_valid_r <= 1'b0;
      i_r         <= '0;
      cur_r       <= '0;
      best_r      <= '0;
      used_r      <= '0;
    end else begin
      if (cfg_valid) begin
        unique case (cfg_index)
          CFG_ABS_GAP:     abs_gap_r <= cfg_data;
          CFG_REL_GAP:     rel_gap_r <= cfg_data[REL_W-1:0];
          CFG_GENOME_SIZE: genome_r  <= cfg_data;
          default: ;
        endcase
      end
      // A new result may replace one that is taken in the same cycle.
      if ((state_r == S_OUT) && (!out_valid_r || !out_stall)) begin
        out_valid_r <= 1'b1;
      end else if (out_valid_r && !out_stall) begin
        out_valid_r <= 1'b0;
      end
      if (shift_en) begin
        hidx_r <= hidx_nxt;
      end

      unique case (state_r)
        S_IDLE: begin
          if (store_new) begin
            cnt_r   <= cnt_r + 1'b1;
            total_r <= sat_add(total_r, SUM_W'(n_sz));
          end
          if (in_acc && in_item.last_mapping) begin
            len_r   <= in_item.edge_length;
            state_r <= S_CLASS;
          end
        end
        S_CLASS: begin
          i_r        <= '0;
          have_row_r <= 1'b0;
          if ((cnt_r == '0) || (tot2 < (SUM_W+2)'(len_r)) || (tot2 > len3)) begin
            res_r   <= res_nxt;
            cnt_r   <= '0;
            total_r <= '0;
            hidx_r  <= '0;
            state_r <= S_OUT;
          end else begin
            state_r <= S_DP;
          end
        end
        S_DP: begin
          if (!have_row_r && (hidx_r == i_r)) begin
            row_r      <= head;
            have_row_r <= 1'b1;
            brk_r      <= 1'b0;
          end else if (have_row_r) begin
            if (stop) begin
              brk_r <= 1'b1;
            end
            if (hidx_last) begin
              have_row_r <= 1'b0;
              if (CW'(i_r) + 1'b1 == cnt_r) begin
                best_r  <= '0;
                cur_r   <= '0;
                state_r <= S_MAX;
              end else begin
                i_r <= i_r + 1'b1;
              end
            end
          end
        end
        S_MAX: begin
          // Strict compare keeps the lowest index on equal scores.
          if (in_range && (head_score > best_r)) begin
            best_r <= head_score;
            cur_r  <= hidx_r;
          end
          if (hidx_last) begin
            used_r  <= '0;
            mis_r   <= '1;
            mie_r   <= '0;
            mms_r   <= '1;
            mme_r   <= '0;
            state_r <= S_TRACE;
          end
        end
        S_TRACE: begin
          if (hidx_r == cur_r) begin
            used_r <= sat_add(used_r, head_sz);
            if (head[O_IS +: P] < mis_r) mis_r <= head[O_IS +: P];
            if (head[O_IE +: P] > mie_r) mie_r <= head[O_IE +: P];
            if (head[O_MS +: P] < mms_r) mms_r <= head[O_MS +: P];
            if (head[O_ME +: P] > mme_r) mme_r <= head[O_ME +: P];
            if (head[O_PV]) begin
              cur_r <= head[O_PR +: IW];
            end else begin
              state_r <= S_FIN;
            end
          end
        end
        S_FIN: begin
          res_r   <= res_nxt;
          cnt_r   <= '0;
          total_r <= '0;
          hidx_r  <= '0;
          state_r <= S_OUT;
        end
        S_OUT: begin
          if (!out_valid_r || !out_stall) begin
            out_item_r <= res_r;
            state_r    <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

endmodule

/* tb/tb_top.sv */
// ---------------------------------------------------------------------------
// tb_top
// Self-checking bench for the colinear mapping chainer. Mappings of each edge
// are driven one item at a time. A local predictor rebuilds the chain from
// its own copy of the stored mappings and configuration, and every result
// item is compared field by field with the oldest prediction. A short
// directed table comes first. Random edges under several gap and genome
// settings follow, with idling on both channels.
// ---------------------------------------------------------------------------
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;
  import cmc_pkg::*;

  localparam int NMAP = DEF_MAX_MAPPINGS;
  localparam longint unsigned SUM_CAP = (64'd1 << SUM_W) - 1;
  localparam longint unsigned POS_CAP = 64'hFFFF_FFFF;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  in_item_t in_item = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  out_item_t out_item;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [FIELD_W-1:0] cfg_data = '0;

  colinear_mapping_chainer DUT (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_item(in_item),
    .out_valid(out_valid), .out_stall(out_stall), .out_item(out_item),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  initial begin
    forever #4 clk = ~clk;
  end

  // Our copy of the configuration registers and of the mapping store.
  longint unsigned gap_abs, gap_rel, genome_len;
  longint unsigned map_is[NMAP], map_ie[NMAP], map_ms[NMAP], map_me[NMAP];
  longint unsigned chain_score[NMAP];
  int chain_prev[NMAP];
  bit chain_prev_ok[NMAP];
  int n_loaded;
  longint unsigned loaded_total;

  out_item_t pending_results[$];
  int errors;
  int items_sent;
  int send_idle_pct;
  int recv_idle_pct;

  // Set by the directed table when the row carries a hand-written result.
  bit use_typed;
  out_item_t typed_result;

  function automatic longint unsigned span(longint unsigned s, longint unsigned e);
    return (e >= s) ? e - s : 0;
  endfunction

  function automatic longint unsigned sat_sum(longint unsigned a, longint unsigned b);
    return (a + b > SUM_CAP) ? SUM_CAP : a + b;
  endfunction

  function automatic bit close_to(longint unsigned end1, longint unsigned start2);
    return !(end1 > start2 + gap_abs) && !(end1 + gap_abs < start2);
  endfunction

  function automatic longint unsigned thinner_side(int k);
    longint unsigned x, y;
    x = span(map_is[k], map_ie[k]);
    y = span(map_ms[k], map_me[k]);
    return (x < y) ? x : y;
  endfunction

  // True when mapping j may follow mapping i in one chain.
  function automatic bit follows(int i, int j);
    longint unsigned g1, g2, mg, mm;
    if (map_is[j] <= gap_abs && map_ie[i] + gap_abs >= genome_len) return 1'b1;
    if (!close_to(map_ie[i], map_is[j]) || !close_to(map_me[i], map_ms[j])) return 1'b0;
    g1 = (map_ie[i] > map_is[j]) ? map_ie[i] - map_is[j] : map_is[j] - map_ie[i];
    g2 = (map_me[i] > map_ms[j]) ? map_me[i] - map_ms[j] : map_ms[j] - map_me[i];
    mg = (g1 > g2) ? g1 : g2;
    mm = (thinner_side(i) > thinner_side(j)) ? thinner_side(i) : thinner_side(j);
    return (mg << 8) <= gap_rel * mm;
  endfunction

  // Classifies the loaded edge and, where it is chainable, builds the best
  // chain and merges its spans.
  function automatic out_item_t chain_edge(longint unsigned len);
    out_item_t r;
    longint unsigned best, used, mis, mie, mms, mme, c;
    int cur;
    r = '0;
    r.loaded_length = loaded_total[SUM_W-1:0];
    if (n_loaded == 0) begin
      r.status = ST_UNMAPPED;
      return r;
    end
    if (loaded_total * 2 > len * 3) begin
      r.status = ST_NON_UNIQUE;
      return r;
    end
    if (loaded_total * 2 < len) begin
      r.status = ST_UNMAPPED;
      return r;
    end
    for (int i = 0; i < n_loaded; i++) begin
      chain_score[i] = span(map_is[i], map_ie[i]);
      chain_prev[i] = 0;
      chain_prev_ok[i] = 1'b0;
    end
    for (int i = 0; i < n_loaded; i++) begin
      for (int j = i + 1; j < n_loaded; j++) begin
        if (follows(i, j)) begin
          c = sat_sum(chain_score[i], span(map_is[j], map_ie[j]));
          if (chain_score[j] < c) begin
            chain_score[j] = c;
            chain_prev[j] = i;
            chain_prev_ok[j] = 1'b1;
          end
        end else if (map_ms[j] > map_me[i] + gap_abs) begin
          break;
        end
      end
    end
    // Strict compare keeps the lowest index on ties; all-zero picks mapping 0.
    best = 0;
    cur = 0;
    for (int i = 0; i < n_loaded; i++) begin
      if (chain_score[i] > best) begin
        best = chain_score[i];
        cur = i;
      end
    end
    used = 0;
    mis = map_is[cur];
    mie = map_ie[cur];
    mms = map_ms[cur];
    mme = map_me[cur];
    forever begin
      used = sat_sum(used, span(map_is[cur], map_ie[cur]));
      if (map_is[cur] < mis) mis = map_is[cur];
      if (map_ie[cur] > mie) mie = map_ie[cur];
      if (map_ms[cur] < mms) mms = map_ms[cur];
      if (map_me[cur] > mme) mme = map_me[cur];
      if (!chain_prev_ok[cur] || chain_prev[cur] >= cur) break;
      cur = chain_prev[cur];
    end
    r.status = (((loaded_total > used) ? loaded_total - used : 0) * 10 >= len) ?
               ST_MISASM : ST_CHAINED;
    r.merged_initial_start = mis[FIELD_W-1:0];
    r.merged_initial_end = mie[FIELD_W-1:0];
    r.merged_mapped_start = mms[FIELD_W-1:0];
    r.merged_mapped_end = mme[FIELD_W-1:0];
    r.chained_length = used[SUM_W-1:0];
    return r;
  endfunction

  // Called for every item the block takes. Mappings beyond the store size
  // are dropped, but a last item still closes the edge.
  task automatic absorb_mapping(input in_item_t it);
    out_item_t r;
    if (n_loaded < NMAP) begin
      map_is[n_loaded] = 64'(it.initial_start);
      map_ie[n_loaded] = 64'(it.initial_end);
      map_ms[n_loaded] = 64'(it.mapped_start);
      map_me[n_loaded] = 64'(it.mapped_end);
      loaded_total = sat_sum(loaded_total,
                             span(64'(it.initial_start), 64'(it.initial_end)));
      n_loaded++;
    end
    if (it.last_mapping) begin
      r = chain_edge(64'(it.edge_length));
      pending_results.insert(pending_results.size(), use_typed ? typed_result : r);
      n_loaded = 0;
      loaded_total = 0;
    end
  endtask

  // Drives one item. Entered and left at a rising edge; the stall is sampled
  // at the falling edge, where it is settled for the coming rising edge.
  task automatic drive_mapping(input in_item_t it);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_item <= it;
    do @(negedge clk); while (in_stall);
    @(posedge clk);
    items_sent++;
    absorb_mapping(it);
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    // Let the result register and the handshake settle before going on.
    repeat (10) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input longint unsigned val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val[FIELD_W-1:0];
    do @(negedge clk); while (!cfg_ready);
    @(posedge clk);
    cfg_valid <= 1'b0;
    case (idx)
      CFG_ABS_GAP: gap_abs = val & POS_CAP;
      CFG_REL_GAP: gap_rel = val & 64'hFFFF;
      CFG_GENOME_SIZE: genome_len = val & POS_CAP;
      default: ;
    endcase
  endtask

  task automatic load_setting(longint unsigned a, longint unsigned r, longint unsigned g);
    wait_drained();
    write_reg(CFG_ABS_GAP, a);
    write_reg(CFG_REL_GAP, r);
    write_reg(CFG_GENOME_SIZE, g);
  endtask

  // One random edge. Most edges are short colinear runs with small gaps;
  // some carry jumps, wrap across the genome end, noisy fields, or overflow
  // the store.
  task automatic random_edge();
    in_item_t edge_items[$];
    in_item_t it;
    int n, kind;
    longint unsigned ms, is, sz, tot, len;
    n = ($urandom_range(24) == 0) ? $urandom_range(NMAP - 4, NMAP + 6) : $urandom_range(1, 6);
    ms = $urandom_range(0, 100000);
    if ($urandom_range(5) == 0 && genome_len > 5000)
      is = genome_len - $urandom_range(1, 3000);
    else
      is = 64'($urandom);
    tot = 0;
    for (int k = 0; k < n; k++) begin
      sz = $urandom_range(0, 3000);
      it = '0;
      it.mapped_start = ms[FIELD_W-1:0];
      it.mapped_end = FIELD_W'(ms + sz + $urandom_range(0, 40) - 20);
      it.initial_start = is[FIELD_W-1:0];
      it.initial_end = FIELD_W'(is + sz);
      if ($urandom_range(11) == 0) begin
        it.initial_start = $urandom;
        it.initial_end = $urandom;
        it.mapped_end = $urandom;
      end
      if (k < NMAP) tot += span(64'(it.initial_start), 64'(it.initial_end));
      edge_items.insert(edge_items.size(), it);
      ms = ms + sz + $urandom_range(0, 60) - 30;
      is = is + sz + $urandom_range(0, 60) - 30;
      if ($urandom_range(9) == 0) is += $urandom_range(0, 1000000);
      if (genome_len != 0 && is >= genome_len) is -= genome_len;
      is &= POS_CAP;
      ms &= POS_CAP;
    end
    kind = $urandom_range(9);
    if (kind <= 6) len = tot * $urandom_range(70, 130) / 100;
    else if (kind == 7) len = tot / 4;
    else if (kind == 8) len = tot * 3;
    else len = 64'($urandom);
    if (len > POS_CAP) len = POS_CAP;
    foreach (edge_items[k]) begin
      edge_items[k].edge_length = len[FIELD_W-1:0];
      edge_items[k].last_mapping = (k == edge_items.size() - 1);
      drive_mapping(edge_items[k]);
    end
  endtask

  task automatic compare_field(input string name, input longint unsigned want,
                               input longint unsigned got);
    if (want != got) begin
      $display("%0t: %s expected %0h actual %0h", $realtime, name, want, got);
      errors++;
    end
  endtask

  // A result is taken at the coming rising edge when valid is high and the
  // stall is low at the falling edge; both are stable there.
  always @(negedge clk) begin
    out_item_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (pending_results.size() == 0) begin
        $display("%0t: unexpected result item, actual %p", $realtime, out_item);
        errors++;
      end else begin
        want = pending_results.pop_front();
        compare_field("status", want.status, out_item.status);
        compare_field("merged_initial_start", want.merged_initial_start,
                      out_item.merged_initial_start);
        compare_field("merged_initial_end", want.merged_initial_end,
                      out_item.merged_initial_end);
        compare_field("merged_mapped_start", want.merged_mapped_start,
                      out_item.merged_mapped_start);
        compare_field("merged_mapped_end", want.merged_mapped_end,
                      out_item.merged_mapped_end);
        compare_field("loaded_length", want.loaded_length, out_item.loaded_length);
        compare_field("chained_length", want.chained_length, out_item.chained_length);
      end
    end
  end

  // The receiver stalls at random at the rate of the current idling phase.
  always @(posedge clk) begin
    out_stall <= rst_n && ($urandom_range(99) < recv_idle_pct);
  end

  typedef struct {
    in_item_t item;
    bit typed;
    out_item_t result;
  } plan_row_t;

  plan_row_t plan[$];

  function automatic in_item_t mk(longint unsigned is, longint unsigned ie,
                                  longint unsigned ms, longint unsigned me,
                                  longint unsigned len, bit last);
    in_item_t it;
    it.initial_start = FIELD_W'(is);
    it.initial_end = FIELD_W'(ie);
    it.mapped_start = FIELD_W'(ms);
    it.mapped_end = FIELD_W'(me);
    it.edge_length = FIELD_W'(len);
    it.last_mapping = last;
    return it;
  endfunction

  function automatic out_item_t res(status_t st, longint unsigned mis, longint unsigned mie,
                                    longint unsigned mms, longint unsigned mme,
                                    longint unsigned tot, longint unsigned used);
    out_item_t r;
    r.status = st;
    r.merged_initial_start = FIELD_W'(mis);
    r.merged_initial_end = FIELD_W'(mie);
    r.merged_mapped_start = FIELD_W'(mms);
    r.merged_mapped_end = FIELD_W'(mme);
    r.loaded_length = SUM_W'(tot);
    r.chained_length = SUM_W'(used);
    return r;
  endfunction

  initial begin
    // Registers are all zero after reset.
    gap_abs = 0;
    gap_rel = 0;
    genome_len = 0;
    n_loaded = 0;
    loaded_total = 0;
    errors = 0;
    items_sent = 0;
    send_idle_pct = 25;
    recv_idle_pct = 47;
    use_typed = 1'b0;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // A lone mapping chains to itself with nothing left over.
    plan.insert(plan.size(), '{mk(100, 200, 0, 100, 100, 1), 1'b1,
                               res(ST_CHAINED, 100, 200, 0, 100, 100, 100)});
    // Ten times the edge length is non-unique; the chain fields stay zero.
    plan.insert(plan.size(), '{mk(0, 1000, 0, 1000, 100, 1), 1'b1,
                               res(ST_NON_UNIQUE, 0, 0, 0, 0, 1000, 0)});
    // A tenth of the edge length is unmapped.
    plan.insert(plan.size(), '{mk(0, 10, 0, 10, 100, 1), 1'b1,
                               res(ST_UNMAPPED, 0, 0, 0, 0, 10, 0)});
    // A reversed range has size zero; with a zero edge length the empty
    // remainder still counts as a misassembly.
    plan.insert(plan.size(), '{mk(500, 100, 7, 3, 0, 1), 1'b1,
                               res(ST_MISASM, 500, 100, 7, 3, 0, 0)});
    // Widest range the fields allow.
    plan.insert(plan.size(), '{mk(0, POS_CAP, POS_CAP, 0, POS_CAP, 1), 1'b1,
                               res(ST_CHAINED, 0, POS_CAP, POS_CAP, 0, POS_CAP, POS_CAP)});
    // Two mappings split by a gap the zero limits do not allow.
    plan.insert(plan.size(), '{mk(1000, 1100, 0, 100, 250, 0), 1'b0, '0});
    plan.insert(plan.size(), '{mk(1110, 1200, 110, 200, 250, 1), 1'b0, '0});
    // Back-to-back mappings with no gap chain under the zero limits.
    plan.insert(plan.size(), '{mk(0, 400, 0, 400, 700, 0), 1'b0, '0});
    plan.insert(plan.size(), '{mk(400, 800, 400, 800, 700, 1), 1'b0, '0});
    // Three mappings with equal scores and a far jump in the middle.
    plan.insert(plan.size(), '{mk(5000, 5100, 0, 100, 300, 0), 1'b0, '0});
    plan.insert(plan.size(), '{mk(900000, 900100, 100, 200, 300, 0), 1'b0, '0});
    plan.insert(plan.size(), '{mk(5100, 5200, 200, 300, 300, 1), 1'b0, '0});
    // Extreme positions on non-last items, then an item closing the edge.
    plan.insert(plan.size(), '{mk(POS_CAP, POS_CAP, POS_CAP, POS_CAP, POS_CAP, 0), 1'b0, '0});
    plan.insert(plan.size(), '{mk(0, 0, 0, 0, 0, 1), 1'b0, '0});

    foreach (plan[r]) begin
      use_typed = plan[r].typed;
      typed_result = plan[r].result;
      drive_mapping(plan[r].item);
    end
    use_typed = 1'b0;

    // A wrap across the genome end: the second mapping starts near zero.
    load_setting(100, 256, 1000000);
    drive_mapping(mk(999000, 999990, 0, 990, 1800, 0));
    drive_mapping(mk(10, 1000, 1000, 1990, 1800, 1));

    // Random edges; the setting changes every few hundred items, the first
    // one being the reset state.
    for (int phase = 0; phase < 6; phase++) begin
      case (phase)
        0: load_setting(0, 0, 0);
        1: load_setting(100, 256, 1000000);
        2: load_setting(POS_CAP, 16'hFFFF, POS_CAP);
        3: load_setting(40, 64, 200000);
        4: load_setting(0, 16'hFFFF, 0);
        default: load_setting(1000, 16'h0080, 2000000);
      endcase
      for (int e = 0; items_sent < 250 * (phase + 1) + 30; e++) begin
        if (items_sent < 530) begin
          send_idle_pct = 25;
          recv_idle_pct = 47;
        end else if (items_sent < 1030) begin
          send_idle_pct = 47;
          recv_idle_pct = 25;
        end else begin
          send_idle_pct = 0;
          recv_idle_pct = 0;
        end
        // Now and then the sender holds off until the block has drained.
        if (e == 5) wait_drained();
        random_edge();
      end
    end

    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (200) @(posedge clk);
    if (errors == 0 && pending_results.size() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

  // Far beyond the slowest legal run, including large edges under stalls.
  initial begin
    #50_000_000;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule
